/* rtl/bcrm_pkg.sv */
// ----------------------------------------------------------------------------
// bcrm_pkg
// Opcodes, instruction lengths and the execute-stage result type shared by
// the register machine step modules.
// ----------------------------------------------------------------------------
package bcrm_pkg;

  localparam logic [7:0] OP_HALT   = 8'd0;
  localparam logic [7:0] OP_LOAD   = 8'd1;
  localparam logic [7:0] OP_CLEAR  = 8'd2;
  localparam logic [7:0] OP_INC    = 8'd3;
  localparam logic [7:0] OP_MOVE   = 8'd4;
  localparam logic [7:0] OP_JUMPEQ = 8'd5;

  localparam logic [63:0] LEN_LOAD  = 64'd10;
  localparam logic [63:0] LEN_SHORT = 64'd2;
  localparam logic [63:0] LEN_MOVE  = 64'd3;
  localparam logic [63:0] LEN_JUMP  = 64'd11;

  localparam logic [63:0] ERROR_MARK = 64'd255;

  // what one executed instruction leaves behind
  typedef struct packed {
    logic        we;
    logic [7:0]  waddr;
    logic [63:0] wdata;
    logic [63:0] pc;
    logic        stopped;
    logic [63:0] reg0;
    logic [7:0]  exit_code;
  } ex_res_t;

endpackage

/* rtl/bcrm_ram.sv */
// ----------------------------------------------------------------------------
// bcrm_ram
// Generic synchronous RAM: one write port, two read ports, registered reads.
// ----------------------------------------------------------------------------
module bcrm_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

/* rtl/bcrm_exec.sv */
// ----------------------------------------------------------------------------
// bcrm_exec
// Execute stage: decodes one instruction, forms the register write, the next
// program counter and the halt status.
// ----------------------------------------------------------------------------
module bcrm_exec (
  input  logic              stopped,
  input  logic [63:0]       pc,
  input  logic [63:0]       reg0,
  input  logic [7:0]        operation,
  input  logic [7:0]        reg_first,
  input  logic [7:0]        reg_second,
  input  logic [63:0]       immediate,
  input  logic              wr_ok_first,
  input  logic              wr_ok_second,
  input  logic [63:0]       opa,
  input  logic [63:0]       opb,
  output bcrm_pkg::ex_res_t res
);
  import bcrm_pkg::*;

  logic        we;
  logic [7:0]  waddr;
  logic [63:0] wdata;
  logic [63:0] pc_nxt;
  logic [63:0] reg0_nxt;
  logic [63:0] reg0_m1;

  always_comb begin
    we     = 1'b0;
    waddr  = reg_first;
    wdata  = immediate;
    pc_nxt = pc;
    case (operation)
      OP_HALT: begin
        we    = 1'b1;
        waddr = 8'd0;
        wdata = opa + 64'd1;
      end
      OP_LOAD: begin
        we     = wr_ok_first;
        pc_nxt = pc + LEN_LOAD;
      end
      OP_CLEAR: begin
        we     = wr_ok_first;
        wdata  = 64'd0;
        pc_nxt = pc + LEN_SHORT;
      end
      OP_INC: begin
        we     = wr_ok_first;
        wdata  = opa + 64'd1;
        pc_nxt = pc + LEN_SHORT;
      end
      OP_MOVE: begin
        we     = wr_ok_second;
        waddr  = reg_second;
        wdata  = opa;
        pc_nxt = pc + LEN_MOVE;
      end
      OP_JUMPEQ: begin
        pc_nxt = (opa == opb) ? immediate : pc + LEN_JUMP;
      end
      default: begin
        we    = 1'b1;
        waddr = 8'd0;
        wdata = ERROR_MARK;
      end
    endcase

    // a stopped machine leaves all state alone
    if (stopped) begin
      we     = 1'b0;
      pc_nxt = pc;
    end

    reg0_nxt = (we && waddr == 8'd0) ? wdata : reg0;
    reg0_m1  = reg0_nxt - 64'd1;

    res.we        = we;
    res.waddr     = waddr;
    res.wdata     = wdata;
    res.pc        = pc_nxt;
    res.stopped   = stopped || (reg0_nxt != 64'd0);
    res.reg0      = reg0_nxt;
    res.exit_code = res.stopped ? reg0_m1[7:0] : 8'd0;
  end

endmodule

/* rtl/bytecode_register_machine_step.sv */
// ----------------------------------------------------------------------------
// bytecode_register_machine_step
// Executes one fetched instruction per input transfer on a 64-bit register
// file and program counter, and returns the next address and halt status.
// ----------------------------------------------------------------------------
// Takes one instruction per clock cycle when the output side keeps up. An
// accepted instruction reads both of its source registers from the register
// file RAM at the accept edge, executes from the execute-stage registers (the
// result of the instruction just before it is forwarded around the RAM) and
// writes back at the edge where its result enters the output register.
// Register file entries that were never written since reset read as zero
// through per-entry valid flops, so no clearing pass is needed. Once register
// zero turns nonzero the machine is stopped: later instructions change
// nothing and repeat the final status.
module bytecode_register_machine_step #(
  parameter int NUM_REGISTERS = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // operation[7:0], reg_first[15:8], reg_second[23:16], immediate[87:24]
  input  logic [87:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // next_address[63:0], halted[64], exit_code[72:65], zero fill[79:73]
  output logic [79:0] out_tdata
);
  import bcrm_pkg::*;

  localparam int AW = $clog2(NUM_REGISTERS);

  logic [7:0]  in_op, in_ra, in_rb;
  logic [63:0] in_imm;
  logic        in_fire;
  logic        in_ok_a, in_ok_b;

  // execute stage
  logic        s1_valid_r;
  logic [7:0]  s1_op_r, s1_ra_r, s1_rb_r;
  logic [63:0] s1_imm_r;
  logic        s1_ok_a_r, s1_ok_b_r;
  logic        s1_va_r, s1_vb_r;
  logic        s1_fire;

  // last write, forwarded to the instruction that read alongside it
  logic        fwd_we_r;
  logic [7:0]  fwd_addr_r;
  logic [63:0] fwd_data_r;

  logic [NUM_REGISTERS-1:0] vld_r;
  logic [63:0] pc_r;
  logic [63:0] reg0_r;
  logic        stopped_r;

  logic        out_valid_r;
  logic [79:0] out_data_r;

  logic [63:0] rdata_a, rdata_b;
  logic [63:0] opa, opb;
  ex_res_t     ex;

  assign in_op   = in_tdata[7:0];
  assign in_ra   = in_tdata[15:8];
  assign in_rb   = in_tdata[23:16];
  assign in_imm  = in_tdata[87:24];
  assign in_ok_a = {1'b0, in_ra} < 9'(NUM_REGISTERS);
  assign in_ok_b = {1'b0, in_rb} < 9'(NUM_REGISTERS);

  assign s1_fire   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_fire;
  assign in_fire   = in_tvalid && in_tready;

  bcrm_ram #(
    .WIDTH (64),
    .DEPTH (NUM_REGISTERS)
  ) u_rf (
    .clk     (clk),
    .we      (s1_fire && ex.we),
    .waddr   (ex.waddr[AW-1:0]),
    .wdata   (ex.wdata),
    .re      (in_fire),
    .raddr_a (in_ra[AW-1:0]),
    .raddr_b (in_rb[AW-1:0]),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  always_comb begin
    opa = s1_va_r ? rdata_a : 64'd0;
    opb = s1_vb_r ? rdata_b : 64'd0;
    if (fwd_we_r && fwd_addr_r == s1_ra_r) begin
      opa = fwd_data_r;
    end
    if (fwd_we_r && fwd_addr_r == s1_rb_r) begin
      opb = fwd_data_r;
    end
  end

  bcrm_exec u_exec (
    .stopped      (stopped_r),
    .pc           (pc_r),
    .reg0         (reg0_r),
    .operation    (s1_op_r),
    .reg_first    (s1_ra_r),
    .reg_second   (s1_rb_r),
    .immediate    (s1_imm_r),
    .wr_ok_first  (s1_ok_a_r),
    .wr_ok_second (s1_ok_b_r),
    .opa          (opa),
    .opb          (opb),
    .res          (ex)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      fwd_we_r    <= 1'b0;
      vld_r       <= '0;
      pc_r        <= 64'd0;
      reg0_r      <= 64'd0;
      stopped_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tready) begin
        s1_valid_r <= in_tvalid;
      end
      if (s1_fire) begin
        fwd_we_r  <= ex.we;
        pc_r      <= ex.pc;
        reg0_r    <= ex.reg0;
        stopped_r <= ex.stopped;
        if (ex.we) begin
          vld_r[ex.waddr[AW-1:0]] <= 1'b1;
        end
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_op_r   <= in_op;
      s1_ra_r   <= in_ra;
      s1_rb_r   <= in_rb;
      s1_imm_r  <= in_imm;
      s1_ok_a_r <= in_ok_a;
      s1_ok_b_r <= in_ok_b;
      s1_va_r   <= in_ok_a && vld_r[in_ra[AW-1:0]];
      s1_vb_r   <= in_ok_b && vld_r[in_rb[AW-1:0]];
    end
    if (s1_fire) begin
      fwd_addr_r <= ex.waddr;
      fwd_data_r <= ex.wdata;
      out_data_r <= {7'd0, ex.exit_code, ex.stopped, ex.pc};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

`ifndef SYNTH
  // the machine never restarts without a reset
  a_stop_sticks: assert property (@(posedge clk) disable iff (!rst_n)
    stopped_r |=> stopped_r)
    else $error("stopped flag cleared");

  // a nonzero register zero always means the machine is stopped
  a_reg0_stops: assert property (@(posedge clk) disable iff (!rst_n)
    (reg0_r != 64'd0) |-> stopped_r)
    else $error("register zero nonzero while running");

  // no register file write or pc change once stopped
  a_frozen: assert property (@(posedge clk) disable iff (!rst_n)
    (stopped_r && s1_fire) |-> (!ex.we && ex.pc == pc_r))
    else $error("state changed after stop");

  // a stalled execute stage keeps its instruction
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_fire) |=> (s1_valid_r && $stable(s1_op_r) && $stable(s1_ra_r)
      && $stable(s1_rb_r) && $stable(s1_imm_r)))
    else $error("execute stage lost its instruction");
`endif

endmodule
